@@ design/rsfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfd_pkg
// Shared types and constants for the run-length sprite frame decoder.
// ----------------------------------------------------------------------------
package rsfd_pkg;

  // Default bounds on the frame size.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration register widths and indexes.
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET_SIZE   = 11'd64;

  // Skip amount: a line skip covers at most 63 lines of the widest frame.
  localparam int AMT_W = 18;

  // Byte classes of a control byte.
  localparam logic [7:0] LINE_SKIP_LO  = 8'h40;
  localparam logic [7:0] LINE_SKIP_HI  = 8'h7F;
  localparam logic [7:0] PIXEL_SKIP_LO = 8'h80;
  localparam logic [7:0] PIXEL_SKIP_HI = 8'hFF;
  localparam logic [7:0] BYTE_NOP      = 8'h00;

  // Output offset saturation.
  localparam int OFFSET_W = 20;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 20'hFFFFF;

  // Operation queue between front and back.
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LITERAL,
    OP_SKIP
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic             start;
    logic [AMT_W-1:0] amount;
    logic [7:0]       data;
  } op_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pixel_offset;
    logic [7:0]          color_index;
    logic                in_range;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/rsfd_chan_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfd_chan_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface rsfd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/rsfd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfd_front
// Accepts stream bytes, tracks the literal count and classifies each byte;
// only literals, skips and frame starts are queued; line skips are width-scaled.
// ----------------------------------------------------------------------------
module rsfd_front #(
  parameter int MAX_WIDTH = rsfd_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  rsfd_chan_if.sink                         in_chan,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] width_eff,
  input  wire rsfd_pkg::q_status_t          q_status,
  output logic                              push,
  output rsfd_pkg::op_t                     op
);
  localparam int AMT_W = rsfd_pkg::AMT_W;

  logic [5:0] lit_r, lit_nxt, lit_eff;
  logic       accept;
  logic [7:0] code;

  assign in_chan.ready = !q_status.full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign code          = in_chan.payload.code_byte;
  assign lit_eff       = in_chan.payload.frame_start ? 6'd0 : lit_r;

  always_comb begin
    push      = 1'b0;
    lit_nxt   = lit_r;
    op.kind   = rsfd_pkg::OP_CLEAR;
    op.start  = in_chan.payload.frame_start;
    op.amount = '0;
    op.data   = code;
    if (accept) begin
      lit_nxt = lit_eff;
      if (lit_eff != 6'd0) begin
        op.kind = rsfd_pkg::OP_LITERAL;
        lit_nxt = lit_eff - 6'd1;
        push    = 1'b1;
      end else begin
        case (code) inside
          [rsfd_pkg::LINE_SKIP_LO:rsfd_pkg::LINE_SKIP_HI]: begin
            op.kind   = rsfd_pkg::OP_SKIP;
            op.amount = AMT_W'(width_eff) * AMT_W'(code[5:0]);
            push      = 1'b1;
          end
          [rsfd_pkg::PIXEL_SKIP_LO:rsfd_pkg::PIXEL_SKIP_HI]: begin
            op.kind   = rsfd_pkg::OP_SKIP;
            op.amount = AMT_W'(code[6:0]);
            push      = 1'b1;
          end
          rsfd_pkg::BYTE_NOP: begin
            push = in_chan.payload.frame_start;
          end
          default: begin
            // Literal run announcement; only a frame start has to reach the back.
            lit_nxt = code[5:0];
            push    = in_chan.payload.frame_start;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= 6'd0;
    end else begin
      lit_r <= lit_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/rsfd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfd_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module rsfd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire rsfd_pkg::op_t       push_op,
  input  wire logic                pop,
  output rsfd_pkg::op_t            head_op,
  output rsfd_pkg::q_status_t      status
);
  localparam int DEPTH = rsfd_pkg::Q_DEPTH;
  localparam int PTR_W = rsfd_pkg::Q_PTR_W;
  localparam int CNT_W = rsfd_pkg::Q_CNT_W;

  rsfd_pkg::op_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign status.count = cnt_r;
  assign head_op      = entry_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/rsfd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfd_back
// Holds the write position, carries out queued operations and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module rsfd_back #(
  parameter int MAX_WIDTH  = rsfd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rsfd_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] limit,
  input  wire rsfd_pkg::op_t                          head_op,
  input  wire rsfd_pkg::q_status_t                    q_status,
  output logic                                        pop,
  rsfd_chan_if.source                                 out_chan
);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int AMT_W = rsfd_pkg::AMT_W;
  localparam int SUM_W = ((POS_W > AMT_W) ? POS_W : AMT_W) + 1;
  localparam int OFF_W = rsfd_pkg::OFFSET_W;

  logic [POS_W-1:0] pos_r, pos_nxt, base, adv;
  logic [AMT_W-1:0] step;
  logic [SUM_W-1:0] sum;
  logic             over;
  logic             out_valid_r, out_valid_nxt;
  rsfd_pkg::out_item_t out_item_r, out_item_nxt;

  assign pop  = !q_status.empty && (!out_valid_r || out_chan.ready);
  assign base = head_op.start ? '0 : pos_r;
  assign step = (head_op.kind == rsfd_pkg::OP_LITERAL) ? AMT_W'(1) : head_op.amount;
  assign sum  = SUM_W'(base) + SUM_W'(step);
  // The position saturates at the limit, and one already past it is pulled down.
  assign over = (base >= limit) || (sum >= SUM_W'(limit));
  assign adv  = over ? limit : POS_W'(sum);

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_item_nxt  = out_item_r;
    if (pop) begin
      case (head_op.kind)
        rsfd_pkg::OP_LITERAL: begin
          pos_nxt                   = adv;
          out_valid_nxt             = 1'b1;
          out_item_nxt.pixel_offset = (32'(base) > 32'(rsfd_pkg::OFFSET_MAX)) ?
                                      rsfd_pkg::OFFSET_MAX : OFF_W'(base);
          out_item_nxt.color_index  = head_op.data;
          out_item_nxt.in_range     = (base < limit);
        end
        rsfd_pkg::OP_SKIP: begin
          pos_nxt = adv;
        end
        default: begin
          pos_nxt = base;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;
endmodule
`default_nettype wire

@@ design/rle_sprite_frame_decoder.sv @@
`default_nettype none
// An accepted literal byte goes through the operation queue and the result register.
// Throughput: one byte per cycle, and one position step in the back end, unless the output stalls.
// A line skip scales by the width in the front, so the back end needs one add and compare.
// Reset is synchronous and active low: position, literal count, queue and output
// valid clear, and both frame size registers return to 64.
// ----------------------------------------------------------------------------
// rle_sprite_frame_decoder
// Run-length sprite frame decoder: turns a compressed byte stream into
// palette-index pixel writes with a linear offset and a range flag.
// ----------------------------------------------------------------------------
module rle_sprite_frame_decoder #(
  parameter int MAX_WIDTH  = rsfd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rsfd_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rsfd_chan_if.sink                          in_chan,
  rsfd_chan_if.source                        out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [rsfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsfd_pkg::CFG_W-1:0]    cfg_wdata
);
  localparam int CW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  // Frame size registers. Writes to indexes beyond the list are ignored.
  logic [rsfd_pkg::CFG_W-1:0] width_r, width_nxt, height_r, height_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        rsfd_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        rsfd_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rsfd_pkg::CFG_RESET_SIZE;
      height_r <= rsfd_pkg::CFG_RESET_SIZE;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Sizes above the supported maximum act as the maximum. The pixel limit is
  // registered; the user must change configuration only while idle (not enforced
  // by the block), so that it is settled before any request reaches the back end.
  logic [CW_W-1:0]  width_eff;
  logic [CH_W-1:0]  height_eff;
  logic [POS_W-1:0] limit_r;

  assign width_eff  = (32'(width_r) > 32'(MAX_WIDTH)) ? CW_W'(MAX_WIDTH) : CW_W'(width_r);
  assign height_eff = (32'(height_r) > 32'(MAX_HEIGHT)) ? CH_W'(MAX_HEIGHT) : CH_W'(height_r);

  always_ff @(posedge clk) begin
    limit_r <= POS_W'(width_eff) * POS_W'(height_eff);
  end

  // Front end: literal count and byte classification.
  logic                q_push;
  rsfd_pkg::op_t       q_push_op;
  logic                q_pop;
  rsfd_pkg::op_t       q_head_op;
  rsfd_pkg::q_status_t q_status;

  rsfd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .width_eff (width_eff),
    .q_status  (q_status),
    .push      (q_push),
    .op        (q_push_op)
  );

  // Operation queue lets the front keep taking bytes while a result waits.
  rsfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .head_op (q_head_op),
    .status  (q_status)
  );

  // Back end: write position and the registered result.
  rsfd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit_r),
    .head_op  (q_head_op),
    .q_status (q_status),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // The front only issues a request into the queue when there is room.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("operation pushed into a full queue");

  // A pushed operation leaves the queue non-empty on the next cycle.
  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (q_status.count != '0))
    else $error("pushed operation lost");

  // A new result appears only after the back end took an operation.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(q_pop))
    else $error("result raised without a dequeued operation");
`endif
endmodule
`default_nettype wire

@@ verif/rle_sprite_frame_decoder_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rle_sprite_frame_decoder_test
// Self-checking bench for the run-length sprite frame decoder. Streams
// directed and random byte sequences with random gaps and back-pressure.
// A scoreboard predicts every pixel write and compares it field by field
// with what the decoder produces.
// ----------------------------------------------------------------------------
module rle_sprite_frame_decoder_test;

  // Byte classification masks and the two register indexes that the block
  // does not implement (writes to them must be ignored).
  localparam logic [7:0] CLASS_MASK       = 8'hC0;
  localparam logic [7:0] LINE_COUNT_MASK  = 8'h3F;
  localparam logic [7:0] PIXEL_COUNT_MASK = 8'h7F;
  localparam logic [rsfd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rsfd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 240;

  // Predicts the pixel writes of the decoder from the bytes it accepts.
  class pixel_write_scoreboard;
    logic [rsfd_pkg::CFG_W-1:0] width_reg;
    logic [rsfd_pkg::CFG_W-1:0] height_reg;
    int unsigned                position;
    logic [5:0]                 run_left;
    rsfd_pkg::out_item_t        pending_writes[$];
    int unsigned                mismatches;

    function new();
      width_reg  = rsfd_pkg::CFG_RESET_SIZE;
      height_reg = rsfd_pkg::CFG_RESET_SIZE;
      position   = 0;
      run_left   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [rsfd_pkg::CFG_IDX_W-1:0] idx,
                            logic [rsfd_pkg::CFG_W-1:0] val);
      if (idx == rsfd_pkg::REG_FRAME_WIDTH) begin
        width_reg = val;
      end else if (idx == rsfd_pkg::REG_FRAME_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    function int unsigned eff_width();
      return (width_reg > rsfd_pkg::DEF_MAX_WIDTH) ? rsfd_pkg::DEF_MAX_WIDTH : width_reg;
    endfunction

    function int unsigned frame_limit();
      int unsigned h;
      h = (height_reg > rsfd_pkg::DEF_MAX_HEIGHT) ? rsfd_pkg::DEF_MAX_HEIGHT : height_reg;
      return eff_width() * h;
    endfunction

    // Moves a position forward, saturating at the frame limit.
    function int unsigned move_to(int unsigned from, int unsigned by, int unsigned lim);
      if (from >= lim || by >= lim - from) return lim;
      return from + by;
    endfunction

    function void note_byte(rsfd_pkg::in_item_t item);
      int unsigned         lim;
      int unsigned         at;
      rsfd_pkg::out_item_t w;
      lim = frame_limit();
      if (item.frame_start) begin
        position = 0;
        run_left = '0;
      end
      if (run_left != 0) begin
        at = position;
        w.pixel_offset = (at > rsfd_pkg::OFFSET_MAX) ? rsfd_pkg::OFFSET_MAX :
                         rsfd_pkg::OFFSET_W'(at);
        w.color_index  = item.code_byte;
        w.in_range     = (at < lim);
        pending_writes.push_back(w);
        position = move_to(at, 1, lim);
        run_left = run_left - 6'd1;
      end else if ((item.code_byte & CLASS_MASK) == rsfd_pkg::LINE_SKIP_LO) begin
        position = move_to(position, eff_width() * (item.code_byte & LINE_COUNT_MASK), lim);
      end else if (item.code_byte[7]) begin
        position = move_to(position, item.code_byte & PIXEL_COUNT_MASK, lim);
      end else if (item.code_byte != rsfd_pkg::BYTE_NOP) begin
        run_left = item.code_byte[5:0];
      end
    endfunction

    function void check_write(rsfd_pkg::out_item_t got);
      rsfd_pkg::out_item_t want;
      if (pending_writes.size() == 0) begin
        $error("unexpected pixel write at offset %0d", got.pixel_offset);
        mismatches++;
        return;
      end
      want = pending_writes.pop_front();
      if (got.pixel_offset !== want.pixel_offset) begin
        $error("pixel_offset: expected %0d, got %0d", want.pixel_offset, got.pixel_offset);
        mismatches++;
      end
      if (got.color_index !== want.color_index) begin
        $error("color_index: expected %0d, got %0d", want.color_index, got.color_index);
        mismatches++;
      end
      if (got.in_range !== want.in_range) begin
        $error("in_range: expected %0d, got %0d", want.in_range, got.in_range);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                           cfg_we;
  logic [rsfd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rsfd_pkg::CFG_W-1:0]     cfg_wdata;

  rsfd_chan_if #(.payload_t(rsfd_pkg::in_item_t))  in_chan ();
  rsfd_chan_if #(.payload_t(rsfd_pkg::out_item_t)) out_chan ();

  rle_sprite_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_write_scoreboard board = new();

  // Idling limits for the two sides, changed from phase to phase. A zero
  // limit gives a stretch where that side never idles.
  int max_in_gap = 10;
  int max_out_stall = 10;
  // When set, the receiver drops ready for this many cycles after its next
  // request, so the decoder fills up and stalls its input.
  int hold_off_cycles = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  // Run limit. The slowest correct run is roughly 2000 bytes plus the long
  // hold-off and the phase drains, so this leaves a wide margin.
  initial begin
    #5_000_000;
    $display("rle_sprite_frame_decoder verification failed");
    $finish;
  end

  // One monitor for everything that crosses the boundary. Values are taken
  // as they stood just before the edge, and an accepted byte is noted before
  // a result at the same edge, although that never matters for the same byte,
  // since its result first passes through the queue and the result register.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) board.write_reg(cfg_index, cfg_wdata);
      if (in_chan.valid && in_chan.ready) board.note_byte(in_chan.payload);
      if (out_chan.valid && out_chan.ready) board.check_write(out_chan.payload);
    end
  end

  // Receiver: draws a stall for every result, and honors a requested long
  // hold-off once the next request has completed.
  initial begin
    int stall;
    forever begin
      if (hold_off_cycles > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = $urandom_range(0, max_out_stall);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Offers one byte and returns at the edge that accepts it. Valid stays
  // high into the next byte when no gap is drawn.
  task automatic send_byte(input logic [7:0] code, input logic start);
    int gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= '{code_byte: code, frame_start: start};
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted write has come out and
  // the back end has had time to finish any pending skip.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sets a new frame size while the decoder is idle. Each batch also pokes
  // one of the unimplemented indexes, which must have no effect.
  task automatic program_frame(input logic [rsfd_pkg::CFG_W-1:0] w,
                               input logic [rsfd_pkg::CFG_W-1:0] h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= rsfd_pkg::REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= rsfd_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= rsfd_pkg::CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A control byte of random class: half the time a skip, otherwise a no-op or a
  // literal announcement.
  function automatic logic [7:0] random_control();
    case ($urandom_range(0, 9))
      0, 1:    return rsfd_pkg::LINE_SKIP_LO | 8'($urandom_range(0, 63));
      2, 3, 4: return rsfd_pkg::PIXEL_SKIP_LO | 8'($urandom_range(0, 127));
      5:       return rsfd_pkg::BYTE_NOP;
      default: return 8'($urandom_range(1, 63));
    endcase
  endfunction

  // One frame of stream. Most frames are well formed: an opening control
  // byte, then literal runs and skips. Some runs are cut short by a new
  // frame start, and one frame in ten is plain noise.
  task automatic send_random_frame(input logic with_start);
    int segs;
    int run;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(4, 20))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end else begin
      send_byte(random_control(), with_start);
      segs = $urandom_range(1, 8);
      repeat (segs) begin
        if ($urandom_range(0, 9) < 6) begin
          run = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
          send_byte(8'(run), 1'b0);
          for (int k = 0; k < run; k++) begin
            if (k > 0 && $urandom_range(0, 49) == 0) begin
              send_byte(random_control(), 1'b1);
              break;
            end
            send_byte(8'($urandom_range(0, 255)), 1'b0);
          end
        end else begin
          send_byte(random_control(), 1'b0);
        end
      end
    end
  endtask

  // A random phase under one frame size. The first frame carries no frame
  // start, so the position left by the previous size is pulled into the
  // new one.
  task automatic run_phase(input logic [rsfd_pkg::CFG_W-1:0] w,
                           input logic [rsfd_pkg::CFG_W-1:0] h,
                           input int in_gap, input int out_stall,
                           input logic pressure);
    int target;
    logic first;
    program_frame(w, h);
    max_in_gap    = in_gap;
    max_out_stall = out_stall;
    if (pressure) hold_off_cycles = 400;
    target = items_sent + ITEMS_PER_PHASE;
    first  = 1'b1;
    while (items_sent < target) begin
      send_random_frame(!first);
      first = 1'b0;
    end
  endtask

  initial begin
    in_chan.valid   <= 1'b0;
    in_chan.payload <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= rsfd_pkg::REG_FRAME_WIDTH;
    cfg_wdata       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, with the reset frame size of 64 by 64. Literal bytes that
    // look like control bytes, one of each skip, a frame start in the middle
    // of a literal run, and writes past the end of the frame.
    send_byte(rsfd_pkg::BYTE_NOP, 1'b1);
    send_byte(8'd3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(rsfd_pkg::PIXEL_SKIP_LO | 8'd1, 1'b0);
    send_byte(rsfd_pkg::LINE_SKIP_LO | 8'd1, 1'b0);
    send_byte(8'd63, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'd1, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(rsfd_pkg::PIXEL_SKIP_HI, 1'b0);
    send_byte(rsfd_pkg::LINE_SKIP_HI, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hED, 1'b0);

    // A zero width makes the frame empty, so every write is flagged out of range.
    program_frame(11'd0, 11'd5);
    send_byte(8'd2, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'hEF, 1'b0);

    // Oversized registers act as the maximum frame. Enough line skips to
    // reach the limit, which no longer fits the offset field and must
    // saturate it.
    program_frame(11'd2047, 11'd2047);
    send_byte(rsfd_pkg::LINE_SKIP_HI, 1'b1);
    repeat (16) send_byte(rsfd_pkg::LINE_SKIP_HI, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'hC3, 1'b0);

    // Random phases over a range of frame sizes and idling patterns. The
    // pressure phase keeps the sender busy while the receiver holds off.
    run_phase(11'd64, 11'd64, 10, 10, 1'b0);
    run_phase(11'd1, 11'd1, 0, 0, 1'b0);
    run_phase(11'd0, 11'd7, 10, 0, 1'b0);
    run_phase(11'd2047, 11'd3, 0, 10, 1'b0);
    run_phase(11'd1024, 11'd1024, 3, 3, 1'b0);
    run_phase(11'd5, 11'd2047, 10, 10, 1'b0);
    run_phase(rsfd_pkg::CFG_W'($urandom_range(0, 2047)),
              rsfd_pkg::CFG_W'($urandom_range(0, 40)), 0, 4, 1'b1);
    run_phase(rsfd_pkg::CFG_W'($urandom_range(1, 32)),
              rsfd_pkg::CFG_W'($urandom_range(1, 32)), 10, 10, 1'b0);

    wait_idle();
    if (board.mismatches == 0) begin
      $display("rle_sprite_frame_decoder verification clean");
    end else begin
      $display("rle_sprite_frame_decoder verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/rsfd_pkg.sv
design/rsfd_chan_if.sv
design/rsfd_front.sv
design/rsfd_queue.sv
design/rsfd_back.sv
design/rle_sprite_frame_decoder.sv
verif/rle_sprite_frame_decoder_test.sv
